// ===== src/fbc_pkg.sv =====
package fbc_pkg;

  // Rows per matrix, clip planes per frustum, spatial axes per box.
  localparam int NUM_ROWS   = 4;
  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int ROW_W      = 2;

  // Index of the row that carries the plane offset (d).
  localparam int ROW_D = NUM_ROWS - 1;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_e;

  // Control from the top level to the plane store.
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
  } store_ctrl_t;

endpackage

// ===== src/fbc_plane_store.sv =====
module fbc_plane_store #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  fbc_pkg::store_ctrl_t                                   ctrl_i,
  input  logic [fbc_pkg::NUM_PLANES-1:0][COORD_WIDTH:0]          wr_data_i,
  output logic [fbc_pkg::NUM_ROWS-1:0][fbc_pkg::NUM_PLANES-1:0][COORD_WIDTH:0] rd_data_o
);
  import fbc_pkg::*;

  // One word per matrix row: that row's coefficient of all six planes.
  logic [NUM_PLANES-1:0][COORD_WIDTH:0] mem_q [NUM_ROWS];
  logic [NUM_ROWS-1:0]                  row_vld_q;
  logic [NUM_ROWS-1:0][NUM_PLANES-1:0][COORD_WIDTH:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_row] <= wr_data_i;
    end
  end

  // Rows never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (ctrl_i.wr_en) begin
      row_vld_q[ctrl_i.wr_row] <= 1'b1;
    end
  end

  // Registered read of every row, taken while rd_en is high.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        rd_q[r] <= row_vld_q[r] ? mem_q[r] : '0;
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== src/fbc_plane_lane.sv =====
module fbc_plane_lane #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = fbc_pkg::FRAC_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         en_i,
  input  logic [fbc_pkg::NUM_ROWS-1:0][COORD_WIDTH:0]  coef_i,
  input  logic [fbc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] box_min_i,
  input  logic [fbc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] box_max_i,
  output logic                                         below_o
);
  import fbc_pkg::*;

  localparam int PW  = 2 * COORD_WIDTH + 1;
  localparam int DW  = COORD_WIDTH + 1 + FRAC_BITS;
  localparam int AW  = ((PW > DW) ? PW : DW) + 2;

  logic signed [COORD_WIDTH:0]   c_s    [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] pt_s   [NUM_AXES];
  logic signed [PW-1:0]          prod_d [NUM_AXES];
  logic signed [PW-1:0]          prod_q [NUM_AXES];
  logic signed [COORD_WIDTH:0]   d_q;
  logic signed [AW-1:0]          acc;

  // p-vertex: max corner where the normal component is >= 0.
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      c_s[k]    = $signed(coef_i[k]);
      pt_s[k]   = coef_i[k][COORD_WIDTH] ? $signed(box_min_i[k]) : $signed(box_max_i[k]);
      prod_d[k] = PW'(c_s[k]) * PW'(pt_s[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      d_q    <= $signed(coef_i[ROW_D]);
    end
  end

  always_comb begin
    acc = AW'(d_q) <<< FRAC_BITS;
    for (int k = 0; k < NUM_AXES; k++) begin
      acc = acc + AW'(prod_q[k]);
    end
  end

  assign below_o = acc[AW-1];

endmodule

// ===== src/frustum_box_cull.sv =====
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+------------------------------------------
// in       | in_valid_i   | in_stall_o   | operation, row_index, entry_col*, box_*
// out      | out_valid_o  | out_stall_i  | box_inside
//
// One transaction per cycle on either channel unless a result is held; a box result
// passes the store read, multiply, and sum and sign registers after its test is taken.
// Loads write the plane store in the cycle they are taken and give no result.
// Reset clears the row valid bits, so every plane is zero and every box
// passes until rows are loaded.
// A stalled result freezes the whole pipeline and in_stall_o rises with it.
module frustum_box_cull #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = fbc_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   operation_i,
  input  logic [1:0]             row_index_i,
  input  logic [COORD_WIDTH-1:0] entry_col0_i,
  input  logic [COORD_WIDTH-1:0] entry_col1_i,
  input  logic [COORD_WIDTH-1:0] entry_col2_i,
  input  logic [COORD_WIDTH-1:0] entry_col3_i,
  input  logic [COORD_WIDTH-1:0] box_min_x_i,
  input  logic [COORD_WIDTH-1:0] box_min_y_i,
  input  logic [COORD_WIDTH-1:0] box_min_z_i,
  input  logic [COORD_WIDTH-1:0] box_max_x_i,
  input  logic [COORD_WIDTH-1:0] box_max_y_i,
  input  logic [COORD_WIDTH-1:0] box_max_z_i,

  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   box_inside_o
);
  import fbc_pkg::*;

  // Pipeline advance: everything moves unless a finished result is held.
  logic en;
  logic in_acc;
  logic is_test;

  logic [COORD_WIDTH:0] e_ext [NUM_ROWS];
  logic [NUM_PLANES-1:0][COORD_WIDTH:0] wr_coef;
  store_ctrl_t store_ctrl;

  logic [NUM_ROWS-1:0][NUM_PLANES-1:0][COORD_WIDTH:0] rd_data;
  logic [NUM_PLANES-1:0][NUM_ROWS-1:0][COORD_WIDTH:0] lane_coef;

  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] box_min_q, box_max_q;
  logic                                 vld1_q, vld2_q, out_vld_q;
  logic [NUM_PLANES-1:0]                below;
  logic                                 box_inside_q;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;
  assign in_acc     = in_valid_i && en;
  assign is_test    = (op_e'(operation_i) == OP_TEST);

  // Plane coefficients from one matrix row: even planes add, odd subtract.
  always_comb begin
    e_ext[0] = {entry_col0_i[COORD_WIDTH-1], entry_col0_i};
    e_ext[1] = {entry_col1_i[COORD_WIDTH-1], entry_col1_i};
    e_ext[2] = {entry_col2_i[COORD_WIDTH-1], entry_col2_i};
    e_ext[3] = {entry_col3_i[COORD_WIDTH-1], entry_col3_i};
    for (int k = 0; k < NUM_AXES; k++) begin
      wr_coef[2*k]   = e_ext[ROW_D] + e_ext[k];
      wr_coef[2*k+1] = e_ext[ROW_D] - e_ext[k];
    end
  end

  always_comb begin
    store_ctrl.rd_en  = en;
    store_ctrl.wr_en  = in_acc && !is_test;
    store_ctrl.wr_row = row_index_i;
  end

  fbc_plane_store #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (store_ctrl),
    .wr_data_i (wr_coef),
    .rd_data_o (rd_data)
  );

  // Stage 1 companion registers: box corners beside the store read.
  always_ff @(posedge clk_i) begin
    if (en) begin
      box_min_q <= {box_min_z_i, box_min_y_i, box_min_x_i};
      box_max_q <= {box_max_z_i, box_max_y_i, box_max_x_i};
    end
  end

  // Regroup the row-major read word per plane.
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        lane_coef[p][r] = rd_data[r][p];
      end
    end
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fbc_plane_lane #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .coef_i    (lane_coef[p]),
      .box_min_i (box_min_q),
      .box_max_i (box_max_q),
      .below_o   (below[p])
    );
  end

  // Valid flags follow the test through read, multiply and sum stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld1_q    <= in_acc && is_test;
      vld2_q    <= vld1_q;
      out_vld_q <= vld2_q;
    end
  end

  // Any negative distance rejects; zero distance counts as inside.
  always_ff @(posedge clk_i) begin
    if (en) begin
      box_inside_q <= ~|below;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign box_inside_o = box_inside_q;

endmodule

// ===== src/fbc_checker.sv =====
module fbc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic operation_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic box_inside_o
);
  import fbc_pkg::*;

  logic test_acc;
  assign test_acc = in_valid_i && !in_stall_o && (op_e'(operation_i) == OP_TEST);

  // Held result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(box_inside_o))
    else $error("result changed while stalled");

  // Input backpressure only comes from a held result.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // A taken test reaches the output if the receiver does not stall on its way.
  a_test_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    test_acc ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("test result missing");

  // Free cycles with no input drain the pipeline and leave no result valid.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_i && !out_stall_i) ##1 (!in_valid_i && !out_stall_i)
      ##1 (!in_valid_i && !out_stall_i) |=> !out_valid_o)
    else $error("result without a test");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fbc_pkg::*;

  localparam int CW        = fbc_pkg::COORD_WIDTH_DEF;
  localparam int CWX       = CW + 1;   // plane coefficient width
  localparam int FRAC      = fbc_pkg::FRAC_BITS_DEF;
  localparam int COL_W     = 3;        // matrix column that holds w
  localparam int ITEM_GOAL = 2000;
  localparam int LONG_HOLD = 200;      // receiver hold-off, in cycles
  localparam int DRAIN_CYC = 10;       // pipeline is 3 deep; wait longer than that
  localparam int CYCLE_MAX = 400000;

  // Handy Q16.16 values
  localparam logic [CW-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [CW-1:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [CW-1:0] Q_NEG_TWO = 32'hFFFE_0000;
  localparam logic [CW-1:0] Q_NEG_1P5 = 32'hFFFE_8000;
  localparam logic [CW-1:0] Q_1P5     = 32'h0001_8000;
  localparam logic [CW-1:0] Q_TWO     = 32'h0002_0000;
  localparam logic [CW-1:0] Q_MIN     = 32'h8000_0000;
  localparam logic [CW-1:0] Q_MAX     = 32'h7FFF_FFFF;

  // Plane store shadow plus the queue of box verdicts still owed by the DUT.
  class cull_scoreboard;
    logic signed [CW:0] plane_coef [NUM_PLANES*NUM_ROWS];
    bit                 verdict_q [$];
    int                 errors;

    function new();
      foreach (plane_coef[i]) plane_coef[i] = '0;
      errors = 0;
    endfunction

    // Called once per accepted input transaction.
    function void note_input(op_e op, logic [1:0] row, logic [3:0][CW-1:0] ent,
                             logic [2:0][CW-1:0] lo, logic [2:0][CW-1:0] hi);
      logic signed [CW:0]  w_term;
      logic signed [CW:0]  v;
      logic signed [127:0] pl_dist;
      logic signed [127:0] coef;
      logic signed [127:0] corner;
      bit                  in_frustum;
      if (op == OP_LOAD) begin
        // row r feeds coefficient r of every plane: w +/- column k
        w_term = CWX'($signed(ent[COL_W]));
        for (int p = 0; p < NUM_PLANES; p++) begin
          v = CWX'($signed(ent[p/2]));
          plane_coef[p*NUM_ROWS + row] = (p % 2) ? w_term - v : w_term + v;
        end
      end else begin
        in_frustum = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++) begin
          pl_dist = 128'(plane_coef[p*NUM_ROWS + ROW_D]);
          pl_dist = pl_dist <<< FRAC;
          for (int k = 0; k < NUM_AXES; k++) begin
            coef   = 128'(plane_coef[p*NUM_ROWS + k]);
            // p-vertex: corner furthest along the normal
            corner = (coef >= 0) ? 128'($signed(hi[k])) : 128'($signed(lo[k]));
            pl_dist = pl_dist + coef * corner;
          end
          if (pl_dist < 0) in_frustum = 1'b0;
        end
        verdict_q.push_back(in_frustum);
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic got);
      bit want;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result box_inside=%0b", got));
      end else begin
        want = verdict_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("box_inside=%0b, expected %0b", got, want));
      end
    endtask
  endclass

  logic          clk_i        = 1'b0;
  logic          rst_ni       = 1'b0;
  logic          in_valid_i   = 1'b0;
  logic          in_stall_o;
  op_e           operation_i  = OP_LOAD;
  logic [1:0]    row_index_i  = '0;
  logic [CW-1:0] entry_col0_i = '0;
  logic [CW-1:0] entry_col1_i = '0;
  logic [CW-1:0] entry_col2_i = '0;
  logic [CW-1:0] entry_col3_i = '0;
  logic [CW-1:0] box_min_x_i  = '0;
  logic [CW-1:0] box_min_y_i  = '0;
  logic [CW-1:0] box_min_z_i  = '0;
  logic [CW-1:0] box_max_x_i  = '0;
  logic [CW-1:0] box_max_y_i  = '0;
  logic [CW-1:0] box_max_z_i  = '0;
  logic          out_valid_o;
  logic          out_stall_i  = 1'b0;
  logic          box_inside_o;

  cull_scoreboard sb = new();

  int items_sent    = 0;
  int cycle_count   = 0;
  int results_taken = 0;
  bit sender_idle   = 1'b0;  // per-item gaps on/off
  bit burst_mode    = 1'b0;  // forces back-to-back transactions
  bit stall_idle    = 1'b1;  // receiver stalls on/off
  bit long_hold_req = 1'b0;  // ask the receiver for one long hold-off

  frustum_box_cull u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .row_index_i  (row_index_i),
    .entry_col0_i (entry_col0_i),
    .entry_col1_i (entry_col1_i),
    .entry_col2_i (entry_col2_i),
    .entry_col3_i (entry_col3_i),
    .box_min_x_i  (box_min_x_i),
    .box_min_y_i  (box_min_y_i),
    .box_min_z_i  (box_min_z_i),
    .box_max_x_i  (box_max_x_i),
    .box_max_y_i  (box_max_y_i),
    .box_max_z_i  (box_max_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .box_inside_o (box_inside_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_MAX) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Output monitor: a result transaction is taken when valid is high and
  // stall is low at the edge. Values are read before the edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(box_inside_o);
  end

  // Receiver: draws a hold-off before each result, now and then switches
  // stalling off for a stretch, and serves one long hold-off on request.
  initial begin
    int hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = stall_idle ? $urandom_range(0, 9) : 0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      results_taken++;
      if (results_taken % 64 == 0) stall_idle = $urandom_range(0, 1);
    end
  end

  function automatic int draw_gap();
    if (burst_mode || !sender_idle) return 0;
    return $urandom_range(0, 9);
  endfunction

  // Drives one input transaction and holds it until the DUT takes it.
  // Valid stays high afterward; the next gap or drain lowers it.
  task automatic send_item(op_e op, logic [1:0] row, logic [3:0][CW-1:0] ent,
                           logic [2:0][CW-1:0] lo, logic [2:0][CW-1:0] hi);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    row_index_i  <= row;
    entry_col0_i <= ent[0];
    entry_col1_i <= ent[1];
    entry_col2_i <= ent[2];
    entry_col3_i <= ent[3];
    box_min_x_i  <= lo[0];
    box_min_y_i  <= lo[1];
    box_min_z_i  <= lo[2];
    box_max_x_i  <= hi[0];
    box_max_y_i  <= hi[1];
    box_max_z_i  <= hi[2];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, row, ent, lo, hi);
    items_sent++;
  endtask

  // Box fields are don't-care on a load; fill them with junk.
  task automatic send_load(logic [1:0] row, logic [CW-1:0] c0, logic [CW-1:0] c1,
                           logic [CW-1:0] c2, logic [CW-1:0] c3);
    send_item(OP_LOAD, row, {c3, c2, c1, c0},
              {$urandom, $urandom, $urandom}, {$urandom, $urandom, $urandom});
  endtask

  // Row and entry fields are don't-care on a test.
  task automatic send_test(logic [CW-1:0] lx, logic [CW-1:0] ly, logic [CW-1:0] lz,
                           logic [CW-1:0] hx, logic [CW-1:0] hy, logic [CW-1:0] hz);
    send_item(OP_TEST, 2'($urandom_range(0, 3)),
              {$urandom, $urandom, $urandom, $urandom}, {lz, ly, lx}, {hz, hy, hx});
  endtask

  // Sender stops and waits until every owed verdict has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.verdict_q.size() != 0);
  endtask

  // Signed value in [-span, span], as a Q16.16 word.
  function automatic logic [CW-1:0] rand_signed(int span);
    int v;
    v = int'($urandom_range(0, 2*span)) - span;
    return CW'(v);
  endfunction

  // Loads a frustum-like matrix: scaled diagonal, w in the corner, small
  // cross terms and a translation row. Sometimes a fully random one instead.
  task automatic load_matrix();
    logic [3:0][CW-1:0] m [NUM_ROWS];
    int                 first;
    int                 r;
    bit                 wild;
    wild = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < NUM_ROWS; i++)
      for (int k = 0; k < 4; k++)
        m[i][k] = wild ? rand_signed(262144) : rand_signed(16384);
    if (!wild) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        m[i][i] = CW'(int'($urandom_range(32768, 131072)));
        if ($urandom_range(0, 7) == 0) m[i][i] = -m[i][i];
      end
      for (int k = 0; k < NUM_AXES; k++) m[ROW_D][k] = rand_signed(524288);
      m[ROW_D][COL_W] = CW'(int'($urandom_range(65536, 4194304)));
    end
    // rows go in any order; only the full set matters
    first = $urandom_range(0, NUM_ROWS - 1);
    for (int i = 0; i < NUM_ROWS; i++) begin
      r = (i + first) % NUM_ROWS;
      send_load(2'(r), m[r][0], m[r][1], m[r][2], m[r][3]);
    end
  endtask

  // A box around the origin region; occasionally full range or inverted.
  task automatic test_random_box();
    logic [2:0][CW-1:0] lo;
    logic [2:0][CW-1:0] hi;
    logic [CW-1:0]      tmp;
    int                 pick;
    pick = $urandom_range(0, 19);
    for (int k = 0; k < NUM_AXES; k++) begin
      if (pick == 0) begin
        lo[k] = $urandom;
        hi[k] = $urandom;
      end else begin
        lo[k] = rand_signed(4194304);
        hi[k] = lo[k] + CW'($urandom_range(0, 1048576));
        if (pick == 1) begin
          tmp   = lo[k];
          lo[k] = hi[k];
          hi[k] = tmp;
        end
      end
    end
    send_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  initial begin
    int  roll;
    int  n_boxes;
    bit  pressure_done;
    bit  pause_done;
    pressure_done = 1'b0;
    pause_done    = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---------------- directed ----------------
    sender_idle = 1'b1;
    // nothing loaded yet: all planes zero, every box passes
    send_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    // min corner above max corner is taken as given
    send_test(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
    // partly loaded: only the offset row, d = 1.0 everywhere
    send_load(2'(ROW_D), '0, '0, '0, Q_ONE);
    send_test('0, '0, '0, '0, '0, '0);
    // x row: left = x + 1, right = 1 - x
    send_load(2'd0, Q_ONE, '0, '0, '0);
    send_test(Q_NEG_ONE, '0, '0, Q_NEG_ONE, '0, '0);    // left distance exactly zero
    send_test(Q_NEG_TWO, '0, '0, Q_NEG_1P5, '0, '0);    // past the left plane
    send_test(Q_1P5, '0, '0, Q_TWO, '0, '0);            // past the right plane
    // unit cube frustum
    send_load(2'd1, '0, Q_ONE, '0, '0);
    send_load(2'd2, '0, '0, Q_ONE, '0);
    send_test(Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, Q_ONE);
    send_test('0, '0, Q_1P5, '0, '0, Q_TWO);
    // extreme entries: coefficients reach the ends of the 33-bit range
    send_load(2'd0, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    send_load(2'd1, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    send_load(2'd2, Q_MIN, Q_MIN, Q_MAX, Q_MAX);
    send_load(2'(ROW_D), Q_MAX, Q_MAX, Q_MIN, Q_MIN);
    send_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    send_test(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
    send_test('0, '0, '0, '0, '0, '0);
    send_test(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_test(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    wait_drained();

    // ---------------- random ----------------
    while (items_sent < ITEM_GOAL) begin
      sender_idle = $urandom_range(0, 2) != 0;
      roll        = $urandom_range(0, 99);

      if (!pressure_done && items_sent >= 600) begin
        // receiver holds off while transactions keep coming: pipeline fills
        // and the input side has to stall
        pressure_done = 1'b1;
        long_hold_req = 1'b1;
        burst_mode    = 1'b1;
        repeat (40) test_random_box();
        burst_mode    = 1'b0;
      end else if (!pause_done && items_sent >= 1200) begin
        pause_done = 1'b1;
        wait_drained();
      end else if (roll < 8) begin
        // noise: any op, every field full range
        send_item(op_e'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  {$urandom, $urandom, $urandom, $urandom},
                  {$urandom, $urandom, $urandom}, {$urandom, $urandom, $urandom});
      end else if (roll < 12) begin
        // lone row rewrite, leaves the rest of the matrix as it was
        send_load(2'($urandom_range(0, 3)), rand_signed(262144), rand_signed(262144),
                  rand_signed(262144), rand_signed(4194304));
      end else begin
        load_matrix();
        n_boxes = $urandom_range(4, 24);
        repeat (n_boxes) test_random_box();
      end
    end

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
